### src/urfs_pkg.sv
// Shared types and constants of the UDP response frame splitter.
package urfs_pkg;

   // Fixed sizes of the frame format.
   localparam logic [15:0] HEADER_BYTES = 16'd8;
   localparam logic [14:0] MAX_SEGMENT  = 15'd16384;
   localparam logic [15:0] FRAME_MIN    = 16'd576;
   localparam logic [15:0] FRAME_MAX    = 16'd65507;
   localparam logic [15:0] FRAME_RESET  = 16'd1400;

   // Result kinds carried on rsp_tuser.
   localparam logic [1:0] KIND_DATA    = 2'd0;
   localparam logic [1:0] KIND_HEADER  = 2'd1;
   localparam logic [1:0] KIND_SUMMARY = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic emit_hdr;
      logic emit_data;
      logic emit_sum;
   } urfs_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic hdr_need;
      logic data_done;
      logic eor;
      logic out_free;
   } urfs_status_type;

endpackage

### src/urfs_dpath.sv
// Datapath of the frame splitter: frame state, piece arithmetic and output register.
module urfs_dpath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [15:0]             csr_wr_data,
   input  logic [15:0]             req_tdata,
   input  logic                    req_tlast,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [63:0]             rsp_tdata,
   output logic [1:0]              rsp_tuser,
   output logic                    rsp_tlast,
   input  urfs_pkg::urfs_cmd_type    cmd,
   output urfs_pkg::urfs_status_type status
);
   import urfs_pkg::*;

   logic [15:0] fs_ff, fs_in;
   logic [14:0] seg_ff;
   logic [14:0] seg_in;
   logic        eor_ff;
   logic [14:0] off_ff, off_in;
   logic [15:0] bif_ff, bif_in;
   logic        cont_ff, cont_in;
   logic [15:0] frames_ff, frames_in;
   logic        hdr_sent_ff, hdr_sent_in;
   logic        out_vld_ff, out_vld_in;
   logic [1:0]  out_kind_ff, out_kind_in;
   logic [14:0] out_off_ff, out_off_in;
   logic [15:0] out_len_ff, out_len_in;
   logic [15:0] out_seq_ff, out_seq_in;
   logic [15:0] out_tot_ff, out_tot_in;
   logic        out_last_ff, out_last_in;

   logic [15:0] next_len;
   logic [14:0] rem;
   logic [16:0] fill;
   logic        fits;
   logic [16:0] gap;
   logic [16:0] off_adv;
   logic        done;
   logic [15:0] data_len;

   // Room left in the open frame and what this step's data piece takes of it.
   always_comb begin
      next_len = cont_ff ? fs_ff - HEADER_BYTES : fs_ff;
      rem      = seg_ff - off_ff;
      fill     = {2'b00, rem} + {1'b0, bif_ff};
      fits     = fill < {1'b0, next_len};
      gap      = {1'b0, next_len} - {1'b0, bif_ff};
      off_adv  = {2'b00, off_ff} + {1'b0, gap[15:0]};
      // A frame already past the size (size lowered mid-request) ends the segment.
      done     = fits || gap[16] || (off_adv >= {2'b00, seg_ff});
      data_len = fits ? {1'b0, rem} : gap[15:0];
   end

   always_comb begin
      fs_in       = fs_ff;
      seg_in      = seg_ff;
      off_in      = off_ff;
      bif_in      = bif_ff;
      cont_in     = cont_ff;
      frames_in   = frames_ff;
      hdr_sent_in = hdr_sent_ff;
      out_vld_in  = out_vld_ff && !rsp_tready;
      out_kind_in = out_kind_ff;
      out_off_in  = out_off_ff;
      out_len_in  = out_len_ff;
      out_seq_in  = out_seq_ff;
      out_tot_in  = out_tot_ff;
      out_last_in = out_last_ff;

      if (csr_wr_en) begin
         if (csr_wr_data < FRAME_MIN) begin
            fs_in = FRAME_MIN;
         end else if (csr_wr_data > FRAME_MAX) begin
            fs_in = FRAME_MAX;
         end else begin
            fs_in = csr_wr_data;
         end
      end

      if (cmd.load) begin
         seg_in = (req_tdata[14:0] > MAX_SEGMENT) ? MAX_SEGMENT : req_tdata[14:0];
         off_in = '0;
      end

      // The header of an empty continuation frame is sent once, then its data follows.
      if (cmd.emit_hdr) begin
         frames_in   = frames_ff + 16'd1;
         hdr_sent_in = 1'b1;
         out_vld_in  = 1'b1;
         out_kind_in = KIND_HEADER;
         out_off_in  = off_ff;
         out_len_in  = HEADER_BYTES;
         out_seq_in  = frames_ff;
         out_tot_in  = '0;
         out_last_in = 1'b0;
      end

      if (cmd.emit_data) begin
         hdr_sent_in = 1'b0;
         out_vld_in  = 1'b1;
         out_kind_in = KIND_DATA;
         out_off_in  = off_ff;
         out_len_in  = data_len;
         out_seq_in  = frames_ff - 16'd1;
         out_tot_in  = '0;
         out_last_in = done && !eor_ff;
         if (fits) begin
            bif_in = bif_ff + {1'b0, rem};
         end else begin
            off_in  = off_adv[14:0];
            bif_in  = '0;
            cont_in = 1'b1;
         end
      end

      if (cmd.emit_sum) begin
         out_vld_in  = 1'b1;
         out_kind_in = KIND_SUMMARY;
         out_off_in  = '0;
         out_len_in  = '0;
         out_seq_in  = '0;
         out_tot_in  = frames_ff;
         out_last_in = 1'b1;
         bif_in      = '0;
         cont_in     = 1'b0;
         frames_in   = 16'd1;
         hdr_sent_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fs_ff       <= FRAME_RESET;
         bif_ff      <= '0;
         cont_ff     <= 1'b0;
         frames_ff   <= 16'd1;
         hdr_sent_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         fs_ff       <= fs_in;
         bif_ff      <= bif_in;
         cont_ff     <= cont_in;
         frames_ff   <= frames_in;
         hdr_sent_ff <= hdr_sent_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      seg_ff      <= seg_in;
      off_ff      <= off_in;
      out_kind_ff <= out_kind_in;
      out_off_ff  <= out_off_in;
      out_len_ff  <= out_len_in;
      out_seq_ff  <= out_seq_in;
      out_tot_ff  <= out_tot_in;
      out_last_ff <= out_last_in;
      if (cmd.load) begin
         eor_ff <= req_tlast;
      end
   end

   assign status.hdr_need  = (bif_ff == '0) && cont_ff && !hdr_sent_ff;
   assign status.data_done = done;
   assign status.eor       = eor_ff;
   assign status.out_free  = !out_vld_ff || rsp_tready;

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {1'b0, out_tot_ff, out_seq_ff, out_len_ff, out_off_ff};

endmodule

### src/urfs_ctrl.sv
// Controller of the frame splitter: sequences the pieces of one segment.
module urfs_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   output urfs_pkg::urfs_cmd_type    cmd,
   input  urfs_pkg::urfs_status_type status
);
   import urfs_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PIECE = 2'd1;
   localparam logic [1:0] ST_SUM   = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_PIECE;
            end
         end
         ST_PIECE: begin
            if (status.out_free) begin
               if (status.hdr_need) begin
                  cmd.emit_hdr = 1'b1;
               end else begin
                  cmd.emit_data = 1'b1;
                  if (status.data_done) begin
                     state_in = status.eor ? ST_SUM : ST_IDLE;
                  end
               end
            end
         end
         ST_SUM: begin
            if (status.out_free) begin
               cmd.emit_sum = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A piece is only written into a free output register.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_hdr || cmd.emit_data || cmd.emit_sum) |-> status.out_free)
      else $error("piece emitted while output register busy");

   // At most one datapath command per cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.emit_hdr, cmd.emit_data, cmd.emit_sum}))
      else $error("conflicting datapath commands");

   // A header is always followed by the data piece of its frame.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit_hdr |=> (state_ff == ST_PIECE) && !status.hdr_need)
      else $error("header not followed by data");

   // A summary only closes a segment that ends its request.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit_sum |-> status.eor)
      else $error("summary without end of request");

endmodule

### src/udp_response_frame_splitter.sv
// Top level of the UDP response frame splitter: controller plus datapath.
// Throughput: a segment is accepted in the idle state, then the block yields one result per
// cycle while the output register is free (the consumer can stall it), set by the single
// output register that takes one piece a cycle.
// The first result of a word is computed in the piece state and registered at the output.
// Reset sets the frame length to 1400 and the frame state to the start of a request.
module udp_response_frame_splitter (
   input  logic        clock,
   input  logic        reset,
   // Configuration: datagram frame length write.
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   // Request words.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [14:0] segment_length, [15] zero
   input  logic        req_tlast,   // end_of_request
   // Result words.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [14:0] piece_offset, [30:15] piece_length,
                                    // [46:31] frame_seqno, [62:47] total_frames, [63] zero
   output logic [1:0]  rsp_tuser,   // [1:0] piece_kind
   output logic        rsp_tlast    // last
);
   import urfs_pkg::*;

   // The controller walks each segment through its pieces: an optional header for
   // every continuation frame, then the data piece, looping frame by frame until the
   // segment is used up, then a request summary when the segment ends the request.
   // The datapath holds the frame state and computes each piece into its output register.
   urfs_cmd_type    cmd;
   urfs_status_type status;

   urfs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // The output register in the datapath lets a new word be accepted while the
   // previous segment's final result still waits for the consumer.
   urfs_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

### tb/sv/udp_response_frame_splitter_tb.sv
// Self-checking testbench for the UDP response frame splitter.
module udp_response_frame_splitter_tb;

   import urfs_pkg::*;

   // The block can emit at most this many result words for one segment.
   localparam int unsigned MAX_PIECES  = 61;
   // Length of the receiver hold-off that is used to fill the block up.
   localparam int unsigned HOLD_CYCLES = 300;

   // One result word, split into its fields.
   typedef struct packed {
      logic [1:0]  kind;
      logic [14:0] offset;
      logic [15:0] length;
      logic [15:0] seqno;
      logic [15:0] total;
      logic        last;
   } piece_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [15:0] csr_wr_data = '0;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata   = '0;   // [14:0] segment_length, [15] zero
   logic        req_tlast   = 1'b0; // end_of_request
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [63:0] rsp_tdata;          // [14:0] offset, [30:15] length, [46:31] seqno,
                                    // [62:47] total, [63] zero
   logic [1:0]  rsp_tuser;          // [1:0] piece_kind
   logic        rsp_tlast;          // last

   udp_response_frame_splitter dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   // Result words that the splitter still owes us, oldest first.
   piece_type expected_pieces[$];

   // Our own copy of the frame state and the frame length register.
   logic [15:0] frame_len_reg  = FRAME_RESET;
   int unsigned fill_bytes     = 0;
   bit          cont_frame     = 1'b0;
   logic [15:0] frame_count    = 16'd1;

   // Idle rates in percent for the sender and the receiver, set per test.
   int unsigned src_idle_pct  = 15;
   int unsigned sink_idle_pct = 15;

   // While sink_hold is high the receiver refuses every word.
   logic sink_hold = 1'b0;
   event sink_hold_go;

   int unsigned mismatches    = 0;
   int unsigned words_checked = 0;
   int unsigned segments_sent = 0;
   int unsigned requests_sent = 0;
   int unsigned sizes_written = 0;

   // The clock runs with a period of four time units.
   initial begin
      forever #2 clock = ~clock;
   end

   // Hard limit on the run time, far above the slowest correct run.
   initial begin
      #4000000;
      $display("Some tests failed");
      $finish;
   end

   // The frame length that the block really uses: the register clamped to its legal range.
   function automatic int unsigned active_frame_len();
      if (frame_len_reg < FRAME_MIN) return 32'(FRAME_MIN);
      if (frame_len_reg > FRAME_MAX) return 32'(FRAME_MAX);
      return 32'(frame_len_reg);
   endfunction

   // Bytes that still fit into the frame that is open now.
   function automatic int unsigned room_left();
      int unsigned fs;
      fs = active_frame_len();
      return (cont_frame ? fs - 32'(HEADER_BYTES) : fs) - fill_bytes;
   endfunction

   function automatic piece_type make_piece(input logic [1:0] kind, input int unsigned offset,
                                            input int unsigned length,
                                            input logic [15:0] seqno,
                                            input logic [15:0] total);
      piece_type p;
      p.kind   = kind;
      p.offset = offset[14:0];
      p.length = length[15:0];
      p.seqno  = seqno;
      p.total  = total;
      p.last   = 1'b0;
      return p;
   endfunction

   // Cuts one segment into frame pieces the way the splitter should, updates the frame
   // state and queues the words that the segment must produce.
   function automatic void predict_pieces(input logic [14:0] seg_len, input logic eor);
      int unsigned fs;
      int unsigned seg;
      int unsigned off;
      int unsigned room;
      int unsigned rest;
      int unsigned cut;
      bit          done;
      piece_type   batch[$];
      fs   = active_frame_len();
      seg  = (seg_len > MAX_SEGMENT) ? 32'(MAX_SEGMENT) : 32'(seg_len);
      off  = 0;
      done = 1'b0;
      do begin
         room = cont_frame ? fs - 32'(HEADER_BYTES) : fs;
         // An empty continuation frame gets a fresh header before any data lands in it.
         if (fill_bytes == 0 && cont_frame) begin
            frame_count = frame_count + 16'd1;
            if (batch.size() < MAX_PIECES)
               batch.push_back(make_piece(KIND_HEADER, off, 32'(HEADER_BYTES),
                                          frame_count - 16'd1, 16'd0));
         end
         rest = seg - off;
         if (rest + fill_bytes < room) begin
            if (batch.size() < MAX_PIECES)
               batch.push_back(make_piece(KIND_DATA, off, rest, frame_count - 16'd1, 16'd0));
            fill_bytes = fill_bytes + rest;
            done = 1'b1;
         end else begin
            // The rest of the frame is filled and the frame is closed.
            cut = room - fill_bytes;
            if (batch.size() < MAX_PIECES)
               batch.push_back(make_piece(KIND_DATA, off, cut, frame_count - 16'd1, 16'd0));
            off        = off + cut;
            fill_bytes = 0;
            cont_frame = 1'b1;
            if (off >= seg) done = 1'b1;
         end
      end while (!done && batch.size() < MAX_PIECES);
      if (eor) begin
         if (batch.size() < MAX_PIECES)
            batch.push_back(make_piece(KIND_SUMMARY, 0, 0, 16'd0, frame_count));
         fill_bytes  = 0;
         cont_frame  = 1'b0;
         frame_count = 16'd1;
      end
      batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) expected_pieces.push_back(batch[i]);
   endfunction

   function automatic void report_mismatch(input string what, input piece_type want,
                                           input piece_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("MISMATCH (%s): expected kind=%0d off=%0d len=%0d seq=%0d total=%0d last=%0b, got kind=%0d off=%0d len=%0d seq=%0d total=%0d last=%0b",
                  what, want.kind, want.offset, want.length, want.seqno, want.total, want.last,
                  got.kind, got.offset, got.length, got.seqno, got.total, got.last);
   endfunction

   // Offers one segment word, with random idle cycles ahead of it, and returns once the
   // splitter has taken it. The expected words are queued when the word is offered.
   task automatic send_segment(input logic [14:0] seg_len, input logic eor);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, seg_len};
      req_tlast  <= eor;
      predict_pieces(seg_len, eor);
      segments_sent++;
      if (eor) requests_sent++;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stops offering words and waits until every expected word has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_pieces.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Writes the frame length register; the block must be idle.
   task automatic write_frame_len(input logic [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en     <= 1'b0;
      frame_len_reg  = value;
      sizes_written++;
   endtask

   // Segment lengths: mostly short, some long, some that fill the open frame exactly,
   // a few above the segment limit and a few empty ones.
   function automatic logic [14:0] random_segment_length();
      int unsigned r;
      int unsigned room;
      r = $urandom_range(99);
      if (r < 55) return 15'($urandom_range(1500));
      if (r < 75) return 15'($urandom_range(MAX_SEGMENT, 1501));
      if (r < 87) begin
         room = room_left();
         return (room > MAX_SEGMENT) ? MAX_SEGMENT : 15'(room);
      end
      if (r < 94) return 15'($urandom_range(32767, MAX_SEGMENT + 1));
      return 15'd0;
   endfunction

   // Default frame length after reset, an exact fill, and an empty segment that opens a
   // continuation frame with a header of its own.
   task automatic test_default_frame();
      send_segment(15'd100, 1'b0);
      send_segment(15'd1300, 1'b0);
      send_segment(15'd0, 1'b0);
      send_segment(15'd2000, 1'b1);
   endtask

   // Frame lengths at and beyond both ends of the legal range, with segment lengths at the
   // extremes of the field.
   task automatic test_frame_len_limits();
      wait_drained();
      write_frame_len(16'd0);
      send_segment(15'd0, 1'b1);
      send_segment(15'h7FFF, 1'b1);
      send_segment(15'd16383, 1'b0);
      send_segment(MAX_SEGMENT, 1'b1);
      wait_drained();
      write_frame_len(FRAME_MIN - 16'd1);
      send_segment(15'd577, 1'b1);
      wait_drained();
      write_frame_len(16'hFFFF);
      repeat (4) send_segment(MAX_SEGMENT, 1'b0);
      send_segment(15'd0, 1'b1);
      wait_drained();
      write_frame_len(FRAME_MAX);
      send_segment(15'd1, 1'b1);
      wait_drained();
      write_frame_len(FRAME_MIN);
      send_segment(15'd576, 1'b0);
      send_segment(15'd568, 1'b1);
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering words,
   // so the block fills up and stalls its input.
   task automatic test_receiver_holdoff();
      wait_drained();
      write_frame_len(16'd1000);
      src_idle_pct = 0;
      -> sink_hold_go;
      repeat (50) send_segment(random_segment_length(), $urandom_range(3) == 0);
      src_idle_pct = 15;
   endtask

   // The sender pauses between two runs of segments until every expected word has come back.
   task automatic test_sender_pause();
      repeat (20) send_segment(random_segment_length(), $urandom_range(3) == 0);
      wait_drained();
      repeat (20) send_segment(random_segment_length(), $urandom_range(3) == 0);
   endtask

   // Random requests in phases, each with its own frame length.
   task automatic test_random_requests();
      logic [15:0] phase_size[4];
      phase_size[0] = FRAME_RESET;
      phase_size[1] = 16'd600;
      phase_size[2] = 16'($urandom_range(65535));
      phase_size[3] = FRAME_MAX;
      for (int p = 0; p < 4; p++) begin
         wait_drained();
         write_frame_len(phase_size[p]);
         // The second phase is a long stretch without idling on either side.
         src_idle_pct  = (p == 1) ? 0 : 15;
         sink_idle_pct = (p == 1) ? 0 : 15;
         repeat (100) send_segment(random_segment_length(), $urandom_range(3) == 0);
      end
      src_idle_pct  = 15;
      sink_idle_pct = 15;
   endtask

   // Receiver hold-off, counted in its own process once a test asks for it.
   initial begin
      forever begin
         @(sink_hold_go);
         sink_hold <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         sink_hold <= 1'b0;
      end
   end

   // The receiver takes words at random, except during a hold-off.
   always @(posedge clock) begin
      rsp_tready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
   end

   // Every word taken from the splitter is compared field by field with the oldest
   // expected word.
   always @(posedge clock) begin : rsp_check
      piece_type got;
      piece_type want;
      string     bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind   = rsp_tuser;
         got.offset = rsp_tdata[14:0];
         got.length = rsp_tdata[30:15];
         got.seqno  = rsp_tdata[46:31];
         got.total  = rsp_tdata[62:47];
         got.last   = rsp_tlast;
         words_checked++;
         if (expected_pieces.size() == 0) begin
            report_mismatch("word with nothing expected", '0, got);
         end else begin
            want = expected_pieces.pop_front();
            bad  = "";
            if (got.kind != want.kind) bad = {bad, " kind"};
            if (got.offset != want.offset) bad = {bad, " offset"};
            if (got.length != want.length) bad = {bad, " length"};
            if (got.seqno != want.seqno) bad = {bad, " seqno"};
            if (got.total != want.total) bad = {bad, " total"};
            if (got.last != want.last) bad = {bad, " last"};
            if (bad != "") report_mismatch({"wrong", bad}, want, got);
         end
      end
   end

   // Reset first, then the tests in turn, then the drain and the verdict.
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_default_frame();
      test_frame_len_limits();
      test_receiver_holdoff();
      test_sender_pause();
      test_random_requests();
      req_tvalid <= 1'b0;
      while (expected_pieces.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (expected_pieces.size() != 0) begin
         mismatches += expected_pieces.size();
         $display("%0d expected words never arrived", expected_pieces.size());
      end
      $display("Sent %0d segments in %0d requests and checked %0d result words,",
               segments_sent, requests_sent, words_checked);
      $display("over %0d frame length settings including both clamps and a long stall.",
               sizes_written + 1);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### filelist.f
src/urfs_pkg.sv
src/urfs_dpath.sv
src/urfs_ctrl.sv
src/udp_response_frame_splitter.sv
tb/sv/udp_response_frame_splitter_tb.sv
